// ===== sv/mcft_pkg.sv =====
package mcft_pkg;

    localparam int NUM_TIMERS_DEF = 16;

    localparam int DT_W     = 16;
    localparam int STAGE_W  = 2;
    localparam int INDEX_W  = 4;
    localparam int DUE_W    = 48;
    localparam int PERIOD_W = 32;
    localparam int FRAME_W  = 32;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_ARM  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CLOSE
    } state_t;

    typedef struct packed {
        logic                arm_en;
        logic [INDEX_W-1:0]  arm_idx;
        logic                arm_frame_mode;
        logic                arm_one_shot;
        logic [STAGE_W-1:0]  arm_stage;
        logic [DUE_W-1:0]    arm_due;
        logic [PERIOD_W-1:0] arm_period;
        logic                fire_en;
    } bank_ctrl_t;

endpackage

// ===== sv/mcft_req_if.sv =====
interface mcft_req_if;
    import mcft_pkg::*;

    logic                valid;
    logic                ready;
    logic                cmd;
    logic [DT_W-1:0]     dt;
    logic [STAGE_W-1:0]  stage;
    logic [INDEX_W-1:0]  entry_index;
    logic                count_frames;
    logic                one_shot;
    logic [DUE_W-1:0]    first_due;
    logic [PERIOD_W-1:0] period;

    modport source (
        output valid, cmd, dt, stage, entry_index, count_frames, one_shot, first_due, period,
        input  ready
    );

    modport sink (
        input  valid, cmd, dt, stage, entry_index, count_frames, one_shot, first_due, period,
        output ready
    );
endinterface

// ===== sv/mcft_rsp_if.sv =====
interface mcft_rsp_if;
    import mcft_pkg::*;

    logic               valid;
    logic               ready;
    logic               fired;
    logic [INDEX_W-1:0] fired_entry;
    logic [DT_W-1:0]    elapsed;
    logic               last;

    modport source (
        output valid, fired, fired_entry, elapsed, last,
        input  ready
    );

    modport sink (
        input  valid, fired, fired_entry, elapsed, last,
        output ready
    );
endinterface

// ===== sv/mcft_entry_bank.sv =====
module mcft_entry_bank #(
    parameter int NUM_TIMERS = mcft_pkg::NUM_TIMERS_DEF,
    parameter int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mcft_pkg::bank_ctrl_t          ctrl,
    input  logic [IDX_W-1:0]              scan_idx,
    input  logic [mcft_pkg::STAGE_W-1:0]  tick_stage,
    input  logic [mcft_pkg::FRAME_W-1:0]  frame_count,
    input  logic [mcft_pkg::DUE_W-1:0]    time_accum,
    output logic                          hit
);
    import mcft_pkg::*;

    logic                active_reg     [NUM_TIMERS];
    logic                frame_mode_reg [NUM_TIMERS];
    logic                one_shot_reg   [NUM_TIMERS];
    logic [STAGE_W-1:0]  stage_reg      [NUM_TIMERS];
    logic [DUE_W-1:0]    due_reg        [NUM_TIMERS];
    logic [PERIOD_W-1:0] period_reg     [NUM_TIMERS];

    logic [DUE_W-1:0] now;
    logic [DUE_W-1:0] due_cur;
    logic [DUE_W-1:0] due_sum;

    // shared compare and reschedule adder, one entry per cycle unless a firing entry waits on the output
    always_comb
    begin
        due_cur = due_reg[scan_idx];
        now     = frame_mode_reg[scan_idx] ? DUE_W'(frame_count) : time_accum;
        due_sum = DUE_W'(due_cur + DUE_W'(period_reg[scan_idx]));
        hit     = active_reg[scan_idx] && (stage_reg[scan_idx] == tick_stage)
                  && (now >= due_cur);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_TIMERS; k++)
            begin
                active_reg[k]     <= 1'b0;
                frame_mode_reg[k] <= 1'b0;
                one_shot_reg[k]   <= 1'b0;
                stage_reg[k]      <= '0;
            end
        end
        else
        begin
            for (int k = 0; k < NUM_TIMERS; k++)
            begin
                if (ctrl.arm_en && (32'(ctrl.arm_idx) == k))
                begin
                    active_reg[k]     <= 1'b1;
                    frame_mode_reg[k] <= ctrl.arm_frame_mode;
                    one_shot_reg[k]   <= ctrl.arm_one_shot;
                    stage_reg[k]      <= ctrl.arm_stage;
                end
                else if (ctrl.fire_en && (32'(scan_idx) == k) && one_shot_reg[k])
                begin
                    active_reg[k] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_TIMERS; k++)
        begin
            if (ctrl.arm_en && (32'(ctrl.arm_idx) == k))
            begin
                due_reg[k]    <= ctrl.arm_due;
                period_reg[k] <= ctrl.arm_period;
            end
            else if (ctrl.fire_en && (32'(scan_idx) == k) && !one_shot_reg[k])
            begin
                due_reg[k] <= due_sum;
            end
        end
    end

endmodule

// ===== sv/multi_channel_frame_time_timer_unit.sv =====
// Bank of NUM_TIMERS frame or time timers. A tick item (cmd 0) advances the frame
// counter by one and the time accumulator by dt, then walks the entries one per cycle
// (unless a firing entry waits on the result port) through a single shared 48-bit
// compare and reschedule adder, sending one item per firing entry in index order and
// a closing item with last set. An arm item (cmd 1) answers with a single item with
// last set; an out-of-range index writes nothing. The request port is ready only
// between items. Counters wrap.
module multi_channel_frame_time_timer_unit #(
    parameter int NUM_TIMERS = mcft_pkg::NUM_TIMERS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    mcft_req_if.sink   req,
    mcft_rsp_if.source rsp
);
    import mcft_pkg::*;

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    scan_idx_reg, scan_idx_next;
    logic [FRAME_W-1:0]  frame_count_reg, frame_count_next;
    logic [DUE_W-1:0]    time_accum_reg, time_accum_next;
    logic [STAGE_W-1:0]  tick_stage_reg, tick_stage_next;
    logic [DT_W-1:0]     dt_reg, dt_next;

    logic                out_valid_reg, out_valid_next;
    logic                out_fired_reg, out_fired_next;
    logic [INDEX_W-1:0]  out_entry_reg, out_entry_next;
    logic [DT_W-1:0]     out_elapsed_reg, out_elapsed_next;
    logic                out_last_reg, out_last_next;

    logic                out_free;
    logic                bank_hit;
    bank_ctrl_t          bank_ctrl;

    mcft_entry_bank #(
        .NUM_TIMERS (NUM_TIMERS),
        .IDX_W      (IDX_W)
    ) u_bank (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (bank_ctrl),
        .scan_idx    (scan_idx_reg),
        .tick_stage  (tick_stage_reg),
        .frame_count (frame_count_reg),
        .time_accum  (time_accum_reg),
        .hit         (bank_hit)
    );

    assign req.ready       = (state_reg == ST_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.fired       = out_fired_reg;
    assign rsp.fired_entry = out_entry_reg;
    assign rsp.elapsed     = out_elapsed_reg;
    assign rsp.last        = out_last_reg;

    always_comb
    begin
        state_next       = state_reg;
        scan_idx_next    = scan_idx_reg;
        frame_count_next = frame_count_reg;
        time_accum_next  = time_accum_reg;
        tick_stage_next  = tick_stage_reg;
        dt_next          = dt_reg;

        out_free         = !out_valid_reg || rsp.ready;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_fired_next   = out_fired_reg;
        out_entry_next   = out_entry_reg;
        out_elapsed_next = out_elapsed_reg;
        out_last_next    = out_last_reg;

        bank_ctrl.arm_en         = 1'b0;
        bank_ctrl.arm_idx        = req.entry_index;
        bank_ctrl.arm_frame_mode = req.count_frames;
        bank_ctrl.arm_one_shot   = req.one_shot;
        bank_ctrl.arm_stage      = req.stage;
        bank_ctrl.arm_due        = req.first_due;
        bank_ctrl.arm_period     = req.period;
        bank_ctrl.fire_en        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.cmd == CMD_ARM)
                    begin
                        bank_ctrl.arm_en = 1'b1;
                        state_next       = ST_CLOSE;
                    end
                    else
                    begin
                        frame_count_next = FRAME_W'(frame_count_reg + FRAME_W'(1));
                        time_accum_next  = DUE_W'(time_accum_reg + DUE_W'(req.dt));
                        tick_stage_next  = req.stage;
                        dt_next          = req.dt;
                        scan_idx_next    = '0;
                        state_next       = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (!bank_hit || out_free)
                begin
                    if (bank_hit)
                    begin
                        bank_ctrl.fire_en = 1'b1;
                        out_valid_next    = 1'b1;
                        out_fired_next    = 1'b1;
                        out_entry_next    = INDEX_W'(scan_idx_reg);
                        out_elapsed_next  = dt_reg;
                        out_last_next     = 1'b0;
                    end
                    if (scan_idx_reg == LAST_IDX)
                    begin
                        state_next = ST_CLOSE;
                    end
                    else
                    begin
                        scan_idx_next = IDX_W'(scan_idx_reg + 1'b1);
                    end
                end
            end
            ST_CLOSE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_fired_next   = 1'b0;
                    out_entry_next   = '0;
                    out_elapsed_next = '0;
                    out_last_next    = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            scan_idx_reg    <= '0;
            frame_count_reg <= '0;
            time_accum_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            scan_idx_reg    <= scan_idx_next;
            frame_count_reg <= frame_count_next;
            time_accum_reg  <= time_accum_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tick_stage_reg  <= tick_stage_next;
        dt_reg          <= dt_next;
        out_fired_reg   <= out_fired_next;
        out_entry_reg   <= out_entry_next;
        out_elapsed_reg <= out_elapsed_next;
        out_last_reg    <= out_last_next;
    end

    // busy from the cycle after an item is taken
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready
    ) else $error("request port ready right after taking an item");

    // a firing entry with room at the output shows up as a firing item
    a_hit_reported: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && bank_hit && out_free) |=> (rsp.valid && rsp.fired)
    ) else $error("firing entry not reported");

    // firing items never close a tick
    a_fired_not_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.fired) |-> !rsp.last
    ) else $error("firing item marked last");

    // a new item is only taken once the previous closing item has been loaded
    a_close_before_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLOSE && state_next == ST_IDLE) |=> (rsp.valid && rsp.last)
    ) else $error("closing item missing");

endmodule
